>>> src/bmtfr_pkg.sv
// ----------------------------------------------------------------------------
// bmtfr_pkg
// Shared types and constants for the bitmap toggle/flip/rotate block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmtfr_pkg;

  localparam int OPCODE_W     = 2;
  localparam int COORD_W      = 3;
  localparam int ROW_BITS_W   = 8;
  localparam int SIDE_DEFAULT = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TOGGLE = 2'd0,
    OP_FLIP   = 2'd1,
    OP_ROTATE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic               fire;
    op_t                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } img_cmd_t;

endpackage

`default_nettype wire

>>> src/bmtfr_if.sv
// ----------------------------------------------------------------------------
// bmtfr_cmd_if / bmtfr_rsp_if
// Valid/ready channels for commands into and row reads out of the image block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmtfr_cmd_if import bmtfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COORD_W-1:0]  row_index;
  logic [COORD_W-1:0]  col_index;

  modport source (output valid, output opcode, output row_index, output col_index,
                  input ready);
  modport sink   (input valid, input opcode, input row_index, input col_index,
                  output ready);
endinterface

interface bmtfr_rsp_if import bmtfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ROW_BITS_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface

`default_nettype wire

>>> src/bmtfr_image.sv
// ----------------------------------------------------------------------------
// bmtfr_image
// Square one-bit image held in flip-flops; applies toggle, flip and rotate as
// registered updates and provides a combinational row read.
// ----------------------------------------------------------------------------
`default_nettype none

module bmtfr_image import bmtfr_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  img_cmd_t              cmd,
  output logic [ROW_BITS_W-1:0] row_bits
);

  localparam int IDX_W = $clog2(SIDE);
  localparam int EXT_W = IDX_W + COORD_W;

  logic [SIDE-1:0]  rows      [SIDE];
  logic [SIDE-1:0]  rows_next [SIDE];
  logic [SIDE-1:0]  flipped   [SIDE];
  logic [SIDE-1:0]  rotated   [SIDE];
  logic [EXT_W-1:0] row_ext;
  logic [EXT_W-1:0] col_ext;
  logic [IDX_W-1:0] ridx;
  logic [IDX_W-1:0] cidx;
  logic             row_ok;
  logic             col_ok;
  logic [SIDE-1:0]  sel;

  assign row_ext = {{IDX_W{1'b0}}, cmd.row};
  assign col_ext = {{IDX_W{1'b0}}, cmd.col};
  assign ridx    = row_ext[IDX_W-1:0];
  assign cidx    = col_ext[IDX_W-1:0];
  assign row_ok  = row_ext < EXT_W'(SIDE);
  assign col_ok  = col_ext < EXT_W'(SIDE);

  // rotate ccw: new[r][c] = old[c][SIDE-1-r]
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      flipped[r] = rows[SIDE-1-r];
      for (int c = 0; c < SIDE; c++) begin
        rotated[r][c] = rows[c][SIDE-1-r];
      end
    end
  end

  always_comb begin
    rows_next = rows;
    if (cmd.fire) begin
      unique case (cmd.op)
        OP_TOGGLE: begin
          if (row_ok && col_ok) begin
            rows_next[ridx][cidx] = ~rows[ridx][cidx];
          end
        end
        OP_FLIP:   rows_next = flipped;
        OP_ROTATE: rows_next = rotated;
        OP_READ:   rows_next = rows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '{default: '0};
    end else begin
      rows <= rows_next;
    end
  end

  assign sel = rows[ridx];

  for (genvar j = 0; j < ROW_BITS_W; j++) begin : g_rd
    if (j < SIDE) begin : g_col
      assign row_bits[j] = row_ok & sel[j];
    end else begin : g_pad
      assign row_bits[j] = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/bitmap_toggle_flip_rotate_top.sv
// ----------------------------------------------------------------------------
// bitmap_toggle_flip_rotate_top
// A read-row result moves from the command register to the result register
// once that register is free, and waits there until taken. Throughput: one
// transaction per cycle while the result register drains; a read waits in the
// command register while an untaken row sits in the result register. Image
// updates are applied by rewiring the image registers as the command fires.
// Reset: synchronous, clears every pixel and empties both register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_toggle_flip_rotate_top import bmtfr_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  bmtfr_cmd_if.sink       cmd,
  bmtfr_rsp_if.source     rsp
);

  logic                  cmd_valid;
  op_t                   op_q;
  logic [COORD_W-1:0]    row_q;
  logic [COORD_W-1:0]    col_q;
  logic                  out_valid;
  logic [ROW_BITS_W-1:0] out_bits;
  logic                  out_free;
  logic                  fire;
  logic                  read_fire;
  img_cmd_t              img_cmd;
  logic [ROW_BITS_W-1:0] rd_bits;

  assign out_free  = !out_valid || rsp.ready;
  assign fire      = cmd_valid && (op_q != OP_READ || out_free);
  assign read_fire = fire && op_q == OP_READ;
  assign cmd.ready = !cmd_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q  <= op_t'(cmd.opcode);
      row_q <= cmd.row_index;
      col_q <= cmd.col_index;
    end
  end

  assign img_cmd = '{fire: fire, op: op_q, row: row_q, col: col_q};

  bmtfr_image #(
    .SIDE(SIDE)
  ) u_image (
    .clk     (clk),
    .rst     (rst),
    .cmd     (img_cmd),
    .row_bits(rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (read_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_fire) begin
      out_bits <= rd_bits;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.row_bits = out_bits;

  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(read_fire))
    else $error("result appeared without a read transaction");

  a_read_needs_room: assert property (@(posedge clk) disable iff (rst)
    read_fire |-> out_free)
    else $error("read issued while result register was blocked");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid && !cmd_valid)
    else $error("register stages not empty after reset");

endmodule

`default_nettype wire
